>>> rtl/hbace_pkg.sv
package hbace_pkg;

	// One vertical pixel pair. The first member sits at the most significant end.
	typedef struct packed {
		logic [7:0] top_red;
		logic [7:0] top_green;
		logic [7:0] top_blue;
		logic [7:0] bottom_red;
		logic [7:0] bottom_green;
		logic [7:0] bottom_blue;
		logic       has_bottom;
		logic       end_of_row;
		logic       end_of_frame;
	} pair_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} stream_t;

	localparam int PC_W = 6;

	// Program entry points.
	localparam logic [PC_W-1:0] PC_FG      = 6'd0;
	localparam logic [PC_W-1:0] PC_BG      = 6'd19;
	localparam logic [PC_W-1:0] PC_GLYPH   = 6'd38;
	localparam logic [PC_W-1:0] PC_SPACE   = 6'd41;
	localparam logic [PC_W-1:0] PC_ROW_RST = 6'd42;
	localparam logic [PC_W-1:0] PC_FRM_RST = 6'd47;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_HB0   = 8'hE2;
	localparam logic [7:0] CH_HB1   = 8'h96;
	localparam logic [7:0] CH_HB2   = 8'h80;

	typedef enum logic [1:0] {
		SRC_LIT,
		SRC_HUN,
		SRC_TEN,
		SRC_ONE
	} src_t;

	typedef enum logic [1:0] {
		COMP_RED,
		COMP_GREEN,
		COMP_BLUE
	} comp_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_TOP_SAME,
		C_BOT_SAME,
		C_LT100,
		C_LT10,
		C_EQ,
		C_NO_ROW,
		C_NO_ROW_FRAME,
		C_NO_FRAME
	} cond_t;

	// One control word. When skip holds, the step emits nothing and jumps to target.
	// Otherwise it emits a byte; the program ends there when fin holds, else it
	// continues at target if link is set and at the next step if not.
	typedef struct packed {
		src_t            src;
		logic [7:0]      lit;
		logic            chan;
		comp_t           comp;
		cond_t           skip;
		logic [PC_W-1:0] target;
		logic            link;
		cond_t           fin;
	} ucode_t;

	function automatic ucode_t uc_lit(input logic [7:0] b);
		ucode_t w;
		w.src    = SRC_LIT;
		w.lit    = b;
		w.chan   = 1'b0;
		w.comp   = COMP_RED;
		w.skip   = C_NEVER;
		w.target = '0;
		w.link   = 1'b0;
		w.fin    = C_NEVER;
		return w;
	endfunction

	function automatic ucode_t uc_dig(input src_t src, input logic chan, input comp_t comp,
			input cond_t skip, input logic [PC_W-1:0] target);
		ucode_t w;
		w        = uc_lit(CH_ZERO);
		w.src    = src;
		w.chan   = chan;
		w.comp   = comp;
		w.skip   = skip;
		w.target = target;
		return w;
	endfunction

	// Steps of one color escape; chan 0 is the foreground, 1 the background.
	function automatic ucode_t uc_escape(input logic chan, input logic [4:0] k);
		ucode_t          w;
		logic [PC_W-1:0] base;
		logic [PC_W-1:0] nxt;
		base = chan ? PC_BG : PC_FG;
		nxt  = base + PC_W'(k) + PC_W'(1);
		unique case (k)
			5'd0: begin
				w        = uc_lit(CH_ESC);
				w.skip   = chan ? C_BOT_SAME : C_TOP_SAME;
				w.target = chan ? PC_GLYPH : PC_BG;
			end
			5'd1:  w = uc_lit(CH_LBRK);
			5'd2:  w = uc_lit(chan ? CH_FOUR : CH_THREE);
			5'd3:  w = uc_lit(CH_EIGHT);
			5'd4:  w = uc_lit(CH_SEMI);
			5'd5:  w = uc_lit(CH_TWO);
			5'd6:  w = uc_lit(CH_SEMI);
			5'd7:  w = uc_dig(SRC_HUN, chan, COMP_RED, C_LT100, nxt);
			5'd8:  w = uc_dig(SRC_TEN, chan, COMP_RED, C_LT10, nxt);
			5'd9:  w = uc_dig(SRC_ONE, chan, COMP_RED, C_NEVER, nxt);
			5'd10: w = uc_lit(CH_SEMI);
			5'd11: w = uc_dig(SRC_HUN, chan, COMP_GREEN, C_LT100, nxt);
			5'd12: w = uc_dig(SRC_TEN, chan, COMP_GREEN, C_LT10, nxt);
			5'd13: w = uc_dig(SRC_ONE, chan, COMP_GREEN, C_NEVER, nxt);
			5'd14: w = uc_lit(CH_SEMI);
			5'd15: w = uc_dig(SRC_HUN, chan, COMP_BLUE, C_LT100, nxt);
			5'd16: w = uc_dig(SRC_TEN, chan, COMP_BLUE, C_LT10, nxt);
			5'd17: w = uc_dig(SRC_ONE, chan, COMP_BLUE, C_NEVER, nxt);
			5'd18: w = uc_lit(CH_M);
			default: w = uc_lit(CH_ZERO);
		endcase
		return w;
	endfunction

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		if (pc < PC_BG) begin
			w = uc_escape(1'b0, 5'(pc - PC_FG));
		end else if (pc < PC_GLYPH) begin
			w = uc_escape(1'b1, 5'(pc - PC_BG));
		end else begin
			unique case (pc)
				6'd38: begin
					w        = uc_lit(CH_HB0);
					w.skip   = C_EQ;
					w.target = PC_SPACE;
				end
				6'd39: w = uc_lit(CH_HB1);
				6'd40: begin
					w        = uc_lit(CH_HB2);
					w.fin    = C_NO_ROW_FRAME;
					w.target = PC_ROW_RST;
					w.link   = 1'b1;
				end
				6'd41: begin
					w     = uc_lit(CH_SPACE);
					w.fin = C_NO_ROW_FRAME;
				end
				6'd42: begin
					w        = uc_lit(CH_ESC);
					w.skip   = C_NO_ROW;
					w.target = PC_FRM_RST;
				end
				6'd43: w = uc_lit(CH_LBRK);
				6'd44: w = uc_lit(CH_ZERO);
				6'd45: w = uc_lit(CH_M);
				6'd46: begin
					w     = uc_lit(CH_LF);
					w.fin = C_NO_FRAME;
				end
				6'd47: w = uc_lit(CH_ESC);
				6'd48: w = uc_lit(CH_LBRK);
				6'd49: w = uc_lit(CH_ZERO);
				6'd50: begin
					w     = uc_lit(CH_M);
					w.fin = C_ALWAYS;
				end
				default: begin
					w     = uc_lit(CH_M);
					w.fin = C_ALWAYS;
				end
			endcase
		end
		return w;
	endfunction

endpackage

>>> rtl/half_block_ansi_color_encoder.sv
// Half-block truecolor cell encoder.
// The pair channel (pair_valid, pair_ready, pair) takes one vertical pixel pair
// per item. The stream channel (stream_valid, stream_ready, stream) returns the
// bytes of the terminal cell, one byte per item, with last_byte set on the
// final byte of each pair.
// A microcode sequencer walks a 51-step program, one step per cycle while no
// waiting byte is stalled. A step either emits a byte or, when its condition
// holds, jumps without emitting (a skipped escape, a suppressed leading zero,
// the glyph replaced by a space, or a skipped row reset). One pair gives 1 to
// 50 bytes out.
// A single output register sits between the sequencer and the stream port, so
// the next pair is taken while the last byte of the previous one still waits.
// When a byte waits and stream_ready is low, the sequencer holds its step and
// the byte stays put.
// Reset clears the sequencer, the output valid flag and the remembered colors,
// so the first cell after reset sends both color escapes.
module half_block_ansi_color_encoder
	import hbace_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pair_valid,
	output logic    pair_ready,
	input  pair_t   pair,
	output logic    stream_valid,
	input  logic    stream_ready,
	output stream_t stream
);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            out_valid_q;
	stream_t         out_q;

	logic [23:0] top_q, bot_q;
	logic        top_same_q, bot_same_q, eq_q, eor_q, eof_q;

	logic [23:0] prev_top_q, prev_bot_q;
	logic        prev_top_known_q, prev_bot_known_q;

	logic [23:0] in_top, in_bot;
	logic        accept, step_en;
	ucode_t      uw;

	logic [23:0] dcolor;
	logic [7:0]  dv;
	logic [1:0]  dh;
	logic [7:0]  drem8;
	logic [6:0]  drem;
	logic [14:0] dprod;
	logic [3:0]  dten, dones;
	logic [6:0]  dten_x10;
	logic [7:0]  step_byte;
	logic        skip_hit, fin_hit;

	assign in_top = {pair.top_blue, pair.top_green, pair.top_red};
	assign in_bot = pair.has_bottom ?
		{pair.bottom_blue, pair.bottom_green, pair.bottom_red} : 24'd0;

	assign pair_ready   = !busy_q;
	assign accept       = pair_valid && pair_ready;
	assign stream_valid = out_valid_q;
	assign stream       = out_q;
	assign step_en      = busy_q && (!out_valid_q || stream_ready);
	assign uw           = ucode_rom(pc_q);

	// Decimal digits of the selected color component.
	always_comb begin
		dcolor = uw.chan ? bot_q : top_q;
		case (uw.comp)
			COMP_GREEN: dv = dcolor[15:8];
			COMP_BLUE:  dv = dcolor[23:16];
			default:    dv = dcolor[7:0];
		endcase
		if (dv >= 8'd200) begin
			dh    = 2'd2;
			drem8 = dv - 8'd200;
		end else if (dv >= 8'd100) begin
			dh    = 2'd1;
			drem8 = dv - 8'd100;
		end else begin
			dh    = 2'd0;
			drem8 = dv;
		end
		drem = drem8[6:0];
		// Multiply by 205/2048 gives the exact tens digit for values below 100.
		dprod    = 15'(drem) * 15'd205;
		dten     = dprod[14:11];
		dten_x10 = {dten, 3'b000} + {2'b00, dten, 1'b0};
		dones    = 4'(drem - dten_x10);
	end

	function automatic logic cond_eval(input cond_t c, input logic [7:0] v);
		logic r;
		unique case (c)
			C_NEVER:        r = 1'b0;
			C_ALWAYS:       r = 1'b1;
			C_TOP_SAME:     r = top_same_q;
			C_BOT_SAME:     r = bot_same_q;
			C_LT100:        r = v < 8'd100;
			C_LT10:         r = v < 8'd10;
			C_EQ:           r = eq_q;
			C_NO_ROW:       r = !eor_q;
			C_NO_ROW_FRAME: r = !eor_q && !eof_q;
			C_NO_FRAME:     r = !eof_q;
			default:        r = 1'b0;
		endcase
		return r;
	endfunction

	always_comb begin
		skip_hit = cond_eval(uw.skip, dv);
		fin_hit  = cond_eval(uw.fin, dv);
		unique case (uw.src)
			SRC_HUN: step_byte = CH_ZERO | {6'd0, dh};
			SRC_TEN: step_byte = CH_ZERO | {4'd0, dten};
			SRC_ONE: step_byte = CH_ZERO | {4'd0, dones};
			default: step_byte = uw.lit;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q           <= 1'b0;
			pc_q             <= '0;
			out_valid_q      <= 1'b0;
			prev_top_q       <= '0;
			prev_bot_q       <= '0;
			prev_top_known_q <= 1'b0;
			prev_bot_known_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				pc_q   <= PC_FG;
				// A row end forgets both colors so the next row restates them.
				if (pair.end_of_row) begin
					prev_top_q       <= '0;
					prev_bot_q       <= '0;
					prev_top_known_q <= 1'b0;
					prev_bot_known_q <= 1'b0;
				end else begin
					prev_top_q       <= in_top;
					prev_bot_q       <= in_bot;
					prev_top_known_q <= 1'b1;
					prev_bot_known_q <= 1'b1;
				end
			end
			if (step_en) begin
				if (skip_hit) begin
					pc_q <= uw.target;
					if (stream_ready) begin
						out_valid_q <= 1'b0;
					end
				end else begin
					out_valid_q <= 1'b1;
					if (fin_hit) begin
						busy_q <= 1'b0;
					end else begin
						pc_q <= uw.link ? uw.target : pc_q + PC_W'(1);
					end
				end
			end else if (stream_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			top_q      <= in_top;
			bot_q      <= in_bot;
			top_same_q <= prev_top_known_q && (prev_top_q == in_top);
			bot_same_q <= prev_bot_known_q && (prev_bot_q == in_bot);
			eq_q       <= in_top == in_bot;
			eor_q      <= pair.end_of_row;
			eof_q      <= pair.end_of_frame;
		end
		if (step_en && !skip_hit) begin
			out_q.out_byte  <= step_byte;
			out_q.last_byte <= fin_hit;
		end
	end

endmodule

>>> rtl/hbace_checker.sv
module hbace_checker
	import hbace_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    pair_valid,
	input logic    pair_ready,
	input pair_t   pair,
	input logic    stream_valid,
	input logic    stream_ready,
	input stream_t stream
);

	// A byte offered on the stream stays until it is taken.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && !stream_ready |=> stream_valid)
		else $error("stream item dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && !stream_ready |=> $stable(stream))
		else $error("stream item changed while stalled");

	// Once a pair is taken, the block works on it before taking another.
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		pair_valid && pair_ready |=> !pair_ready)
		else $error("pair taken back to back");

	// While a byte that is not the last of its cell waits, no new pair enters.
	a_no_take_mid_cell: assert property (@(posedge clk) disable iff (!arst_n)
		stream_valid && !stream.last_byte |-> !pair_ready)
		else $error("pair accepted in the middle of a cell");

endmodule

bind half_block_ansi_color_encoder hbace_checker u_hbace_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hbace_pkg::*;

	localparam int RANDOM_PAIRS   = 295;
	localparam int SQUEEZE_AT     = 60;
	localparam int SQUEEZE_CYCLES = 600;
	localparam int CYCLE_LIMIT    = 10000000;
	localparam int MAX_REPORTS    = 10;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    pair_valid = 1'b0;
	logic    pair_ready;
	pair_t   pair = '0;
	logic    stream_valid;
	logic    stream_ready = 1'b0;
	stream_t stream;

	half_block_ansi_color_encoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pair_valid   (pair_valid),
		.pair_ready   (pair_ready),
		.pair         (pair),
		.stream_valid (stream_valid),
		.stream_ready (stream_ready),
		.stream       (stream)
	);

	// Pending pixel pairs and the idle cycles that follow each one.
	pair_t pair_queue[$];
	int    gap_queue[$];

	// Remembered colors of the previous cell in the row, packed {red, green, blue}.
	logic [23:0] top_seen = '0;
	logic [23:0] bottom_seen = '0;
	logic        top_seen_valid = 1'b0;
	logic        bottom_seen_valid = 1'b0;

	logic [7:0] cell_seq[$];
	stream_t    cell_bytes[$];

	int   error_count = 0;
	int   pairs_taken = 0;
	int   cycle_count = 0;
	logic pair_taken = 1'b0;
	logic offering = 1'b0;
	int   send_wait = 0;

	logic squeeze_done = 1'b0;
	int   squeeze_left = 0;
	int   rx_stall_left = 0;
	int   rx_phase_left = 0;
	logic rx_steady = 1'b0;

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Leans toward one- and two-digit values so that every digit count is common.
	function automatic logic [7:0] random_level();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 8'($urandom_range(0, 9));
		else if (r == 1)
			return 8'($urandom_range(10, 99));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [23:0] random_color();
		return {random_level(), random_level(), random_level()};
	endfunction

	function automatic pair_t make_pair(logic [23:0] top_rgb, logic [23:0] bottom_rgb,
			logic has_bottom, logic end_of_row, logic end_of_frame);
		pair_t p;
		{p.top_red, p.top_green, p.top_blue}          = top_rgb;
		{p.bottom_red, p.bottom_green, p.bottom_blue} = bottom_rgb;
		p.has_bottom   = has_bottom;
		p.end_of_row   = end_of_row;
		p.end_of_frame = end_of_frame;
		return p;
	endfunction

	function automatic void queue_pair(pair_t p, int gap);
		pair_queue = {pair_queue, p};
		gap_queue  = {gap_queue, gap};
	endfunction

	function automatic void emit_char(logic [7:0] b);
		cell_seq = {cell_seq, b};
	endfunction

	function automatic void put_decimal(logic [7:0] v);
		if (v >= 8'd100)
			emit_char(CH_ZERO + v / 8'd100);
		if (v >= 8'd10)
			emit_char(CH_ZERO + (v / 8'd10) % 8'd10);
		emit_char(CH_ZERO + v % 8'd10);
	endfunction

	function automatic void put_color_escape(logic [7:0] selector, logic [23:0] rgb);
		emit_char(CH_ESC);
		emit_char(CH_LBRK);
		emit_char(selector);
		emit_char(CH_EIGHT);
		emit_char(CH_SEMI);
		emit_char(CH_TWO);
		emit_char(CH_SEMI);
		put_decimal(rgb[23:16]);
		emit_char(CH_SEMI);
		put_decimal(rgb[15:8]);
		emit_char(CH_SEMI);
		put_decimal(rgb[7:0]);
		emit_char(CH_M);
	endfunction

	function automatic void put_attr_reset();
		emit_char(CH_ESC);
		emit_char(CH_LBRK);
		emit_char(CH_ZERO);
		emit_char(CH_M);
	endfunction

	// Works out the bytes of one terminal cell and advances the remembered colors.
	function automatic void encode_cell(pair_t p);
		logic [23:0] top_rgb;
		logic [23:0] bottom_rgb;
		logic        top_repeat;
		logic        bottom_repeat;
		stream_t     s;
		top_rgb       = {p.top_red, p.top_green, p.top_blue};
		bottom_rgb    = p.has_bottom ? {p.bottom_red, p.bottom_green, p.bottom_blue} : 24'd0;
		top_repeat    = top_seen_valid && top_seen == top_rgb;
		bottom_repeat = bottom_seen_valid && bottom_seen == bottom_rgb;
		cell_seq.delete();
		if (!top_repeat)
			put_color_escape(CH_THREE, top_rgb);
		if (!bottom_repeat)
			put_color_escape(CH_FOUR, bottom_rgb);
		if (top_rgb == bottom_rgb) begin
			emit_char(CH_SPACE);
		end else begin
			emit_char(CH_HB0);
			emit_char(CH_HB1);
			emit_char(CH_HB2);
		end
		top_seen          = top_rgb;
		bottom_seen       = bottom_rgb;
		top_seen_valid    = 1'b1;
		bottom_seen_valid = 1'b1;
		if (p.end_of_row) begin
			put_attr_reset();
			emit_char(CH_LF);
			top_seen          = '0;
			bottom_seen       = '0;
			top_seen_valid    = 1'b0;
			bottom_seen_valid = 1'b0;
		end
		if (p.end_of_frame)
			put_attr_reset();
		foreach (cell_seq[i]) begin
			s.out_byte  = cell_seq[i];
			s.last_byte = (i == cell_seq.size() - 1);
			cell_bytes  = {cell_bytes, s};
		end
	endfunction

	// Both channels are observed here at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (pair_valid && pair_ready) begin
				encode_cell(pair);
				pairs_taken++;
				pair_taken = 1'b1;
			end
			if (stream_valid && stream_ready) begin
				if (cell_bytes.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("cycle %0d: unexpected byte %02h last %0b", cycle_count,
							stream.out_byte, stream.last_byte);
				end else if (stream != cell_bytes[0]) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("cycle %0d: expected byte %02h last %0b, got byte %02h last %0b",
							cycle_count, cell_bytes[0].out_byte, cell_bytes[0].last_byte,
							stream.out_byte, stream.last_byte);
					void'(cell_bytes.pop_front());
				end else begin
					void'(cell_bytes.pop_front());
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (pair_taken) begin
				offering   = 1'b0;
				pair_taken = 1'b0;
			end
			if (!offering) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (pair_queue.size() != 0) begin
					send_wait = gap_queue.pop_front();
					pair <= pair_queue.pop_front();
					offering = 1'b1;
				end
			end
			pair_valid <= offering;
		end
	end

	// The receiver moves at random between steady and stalling stretches. Once, it holds off
	// long enough for the block to back up into the pair channel.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!squeeze_done && pairs_taken >= SQUEEZE_AT) begin
				squeeze_done = 1'b1;
				squeeze_left = SQUEEZE_CYCLES;
			end
			if (rx_phase_left == 0) begin
				rx_phase_left = $urandom_range(100, 600);
				rx_steady     = ($urandom_range(0, 2) == 0);
			end else begin
				rx_phase_left--;
			end
			if (squeeze_left > 0) begin
				squeeze_left--;
				stream_ready <= 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				stream_ready <= 1'b0;
			end else if (!rx_steady && $urandom_range(0, 99) < 30) begin
				rx_stall_left = idle_length();
				stream_ready <= 1'b0;
			end else begin
				stream_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		pair_t       p;
		logic [23:0] top_rgb;
		logic [23:0] bottom_rgb;
		logic        quiet;
		int          rows;
		int          cells;
		int          r;
		int          random_pairs;

		// Directed cells. The first one after reset sends both escapes.
		queue_pair(make_pair(24'h000000, 24'h000000, 1'b1, 1'b0, 1'b0), 0);
		queue_pair(make_pair(24'h000000, 24'h000000, 1'b1, 1'b0, 1'b0), 0);
		queue_pair(make_pair(24'hFFFFFF, 24'h000000, 1'b1, 1'b0, 1'b0), 1);
		queue_pair(make_pair(24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 1'b0), 0);
		queue_pair(make_pair({8'd9, 8'd10, 8'd99}, {8'd100, 8'd199, 8'd255}, 1'b1, 1'b0, 1'b0), 0);
		queue_pair(make_pair({8'd9, 8'd10, 8'd99}, {8'd100, 8'd199, 8'd255}, 1'b1, 1'b0, 1'b0), 2);
		// A missing bottom pixel is black whatever its fields hold.
		queue_pair(make_pair(24'h000000, 24'hFFA55A, 1'b0, 1'b0, 1'b0), 0);
		queue_pair(make_pair(24'h000000, 24'h5AA5FF, 1'b0, 1'b1, 1'b0), 0);
		queue_pair(make_pair({8'd1, 8'd2, 8'd3}, {8'd1, 8'd2, 8'd3}, 1'b1, 1'b0, 1'b0), 0);
		// Frame end alone keeps the remembered colors.
		queue_pair(make_pair({8'd1, 8'd2, 8'd3}, {8'd1, 8'd2, 8'd3}, 1'b1, 1'b0, 1'b1), 0);
		queue_pair(make_pair({8'd1, 8'd2, 8'd3}, {8'd1, 8'd2, 8'd3}, 1'b1, 1'b0, 1'b0), 1);
		queue_pair(make_pair({8'd128, 8'd64, 8'd32}, {8'd7, 8'd0, 8'd250}, 1'b1, 1'b1, 1'b1), 0);
		queue_pair(make_pair({8'd200, 8'd0, 8'd0}, {8'd200, 8'd0, 8'd0}, 1'b1, 1'b1, 1'b0), 0);
		queue_pair(make_pair(24'h000000, 24'hFFFFFF, 1'b0, 1'b1, 1'b1), 0);
		queue_pair(make_pair(24'hFFFFFF, 24'hFFFFFF, 1'b0, 1'b0, 1'b1), 3);
		queue_pair(make_pair(24'hFFFFFF, {8'd255, 8'd128, 8'd0}, 1'b1, 1'b1, 1'b1), 0);

		// Random frames of rows, with repeated colors so that escapes are often skipped.
		// A few markers are flipped to give broken frames.
		random_pairs = 0;
		top_rgb      = '0;
		bottom_rgb   = '0;
		while (random_pairs < RANDOM_PAIRS) begin
			rows  = $urandom_range(1, 4);
			quiet = ($urandom_range(0, 3) == 0);
			for (int row = 0; row < rows; row++) begin
				cells = ($urandom_range(0, 7) == 0) ? $urandom_range(12, 30) :
					$urandom_range(1, 8);
				if (cells > RANDOM_PAIRS - random_pairs)
					cells = RANDOM_PAIRS - random_pairs;
				for (int col = 0; col < cells; col++) begin
					if ($urandom_range(0, 99) >= 45)
						top_rgb = random_color();
					r = $urandom_range(0, 99);
					if (r < 12)
						bottom_rgb = top_rgb;
					else if (r >= 55)
						bottom_rgb = random_color();
					p = make_pair(top_rgb, bottom_rgb, $urandom_range(0, 9) != 0,
						col == cells - 1, row == rows - 1 && col == cells - 1);
					r = $urandom_range(0, 99);
					if (r < 4)
						p.end_of_frame = ~p.end_of_frame;
					else if (r < 8)
						p.end_of_row = ~p.end_of_row;
					queue_pair(p, quiet ? 0 : idle_length());
					random_pairs++;
				end
			end
		end

		while (pair_queue.size() != 0 || pair_valid)
			@(posedge clk);
		while (cell_bytes.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

>>> files.f
rtl/hbace_pkg.sv
rtl/half_block_ansi_color_encoder.sv
rtl/hbace_checker.sv
tb/testbench.sv
